@@ rtl/core/nstd_pkg.sv @@
// Shared types, codes and defaults for the synthetic traffic destination block.
package nstd_pkg;

    // Default sizing of the block.
    localparam int MAX_DIM_DEFAULT     = 16;
    localparam int RANDOM_BITS_DEFAULT = 16;

    // Configuration port geometry.
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;
    localparam int SIZE_REG_W = 5;
    localparam int MODE_REG_W = 3;

    // Register reset values.
    localparam logic [SIZE_REG_W-1:0] COLUMNS_RESET = 5'd4;
    localparam logic [SIZE_REG_W-1:0] ROWS_RESET    = 5'd4;
    localparam logic [MODE_REG_W-1:0] MODE_RESET    = 3'd2;

    // Register index, taken from paddr[3:2].
    typedef enum logic [1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_MODE    = 2'd2,
        REG_NONE    = 2'd3
    } reg_index_t;

    // Traffic mode codes.
    typedef enum logic [MODE_REG_W-1:0] {
        MODE_UNIFORM    = 3'd1,
        MODE_COMPLEMENT = 3'd2,
        MODE_TRANSPOSE  = 3'd3,
        MODE_REVERSE    = 3'd4
    } mode_t;

    typedef struct packed {
        logic [7:0]  source_node;
        logic [15:0] random_value;
    } req_t;

    typedef struct packed {
        logic [7:0] destination_node;
        logic       source_out_of_range;
    } rsp_t;

    // Sideband that travels with an item down the cell row.
    typedef struct packed {
        logic                  valid;
        logic [MODE_REG_W-1:0] mode;
        logic                  out_of_range;
    } ctrl_t;

endpackage

@@ rtl/core/nstd_div_cell.sv @@
// One restoring-division step for two dividends, registered, with pipeline flow control.
module nstd_div_cell #(
    parameter int N  = 16,
    parameter int RW = 10
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nstd_pkg::ctrl_t ctrl_in,
    output logic            ready_up,
    input  logic [RW-1:0]   rem_a_in,
    input  logic [N-1:0]    work_a_in,
    input  logic [RW-1:0]   rem_b_in,
    input  logic [N-1:0]    work_b_in,
    input  logic [RW-1:0]   divisor_a,
    input  logic [RW-1:0]   divisor_b,
    output nstd_pkg::ctrl_t ctrl_out,
    input  logic            ready_down,
    output logic [RW-1:0]   rem_a_out,
    output logic [N-1:0]    work_a_out,
    output logic [RW-1:0]   rem_b_out,
    output logic [N-1:0]    work_b_out
);

    logic                                valid_reg, valid_next;
    logic [nstd_pkg::MODE_REG_W-1:0]     mode_reg, mode_next;
    logic                                oor_reg, oor_next;
    logic [RW-1:0]                       rem_a_reg, rem_a_next;
    logic [RW-1:0]                       rem_b_reg, rem_b_next;
    logic [N-1:0]                        work_a_reg, work_a_next;
    logic [N-1:0]                        work_b_reg, work_b_next;

    logic [RW:0] shift_a, shift_b, diff_a, diff_b;
    logic        ge_a, ge_b;

    assign ready_up = !valid_reg || ready_down;

    // Bring down the next dividend bit, subtract if it fits.
    always_comb
    begin
        shift_a = {rem_a_in, work_a_in[N-1]};
        shift_b = {rem_b_in, work_b_in[N-1]};
        ge_a    = shift_a >= {1'b0, divisor_a};
        ge_b    = shift_b >= {1'b0, divisor_b};
        diff_a  = shift_a - {1'b0, divisor_a};
        diff_b  = shift_b - {1'b0, divisor_b};
    end

    always_comb
    begin
        valid_next  = valid_reg;
        mode_next   = mode_reg;
        oor_next    = oor_reg;
        rem_a_next  = rem_a_reg;
        rem_b_next  = rem_b_reg;
        work_a_next = work_a_reg;
        work_b_next = work_b_reg;
        if (ready_up)
        begin
            valid_next  = ctrl_in.valid;
            mode_next   = ctrl_in.mode;
            oor_next    = ctrl_in.out_of_range;
            rem_a_next  = ge_a ? diff_a[RW-1:0] : shift_a[RW-1:0];
            rem_b_next  = ge_b ? diff_b[RW-1:0] : shift_b[RW-1:0];
            work_a_next = {work_a_in[N-2:0], ge_a};
            work_b_next = {work_b_in[N-2:0], ge_b};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        oor_reg    <= oor_next;
        rem_a_reg  <= rem_a_next;
        rem_b_reg  <= rem_b_next;
        work_a_reg <= work_a_next;
        work_b_reg <= work_b_next;
    end

    assign ctrl_out   = '{valid: valid_reg, mode: mode_reg, out_of_range: oor_reg};
    assign rem_a_out  = rem_a_reg;
    assign rem_b_out  = rem_b_reg;
    assign work_a_out = work_a_reg;
    assign work_b_out = work_b_reg;

endmodule

@@ rtl/core/nstd_map_stage.sv @@
// Final cell: applies the traffic mode to the split source and holds the result item.
module nstd_map_stage #(
    parameter int MAX_DIM = 16,
    parameter int N       = 16,
    parameter int RW      = 10
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  nstd_pkg::ctrl_t          ctrl_in,
    output logic                     ready_up,
    input  logic [RW-1:0]            rem_a,
    input  logic [N-1:0]             work_a,
    input  logic [RW-1:0]            rem_b,
    input  logic [$clog2(MAX_DIM+1)-1:0] size_x,
    input  logic [$clog2(MAX_DIM+1)-1:0] size_y,
    output nstd_pkg::rsp_t           rsp,
    output logic                     rsp_valid,
    input  logic                     rsp_ready
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = 2 * DIM_W;
    localparam int XB    = $clog2(MAX_DIM);
    localparam int W     = 2 * XB;
    localparam int BW    = $clog2(XB + 1);
    localparam int DW    = (CW > W) ? ((CW > 8) ? CW : 8) : ((W > 8) ? W : 8);

    // Index bits for a dimension: ceil(log2(size)), at least one.
    function automatic logic [BW-1:0] bits_for(input logic [DIM_W-1:0] s);
        logic [BW-1:0] b;
        b = BW'(1);
        for (int k = 0; k < XB; k++)
        begin
            if (s > (DIM_W'(1) << k))
            begin
                b = BW'(k + 1);
            end
        end
        return b;
    endfunction

    logic                 valid_reg, valid_next;
    nstd_pkg::rsp_t       rsp_reg, rsp_next;

    logic [DIM_W-1:0] x_d, y_d;
    logic [DIM_W-1:0] mul_a, mul_b, add_c;
    logic [CW-1:0]    linear;
    logic [BW-1:0]    xb, yb;
    logic [BW:0]      nbits;
    logic [BW:0]      shamt;
    logic [W-1:0]     joined, rev, rev_out;
    logic [DW-1:0]    dest;

    assign ready_up = !valid_reg || rsp_ready;

    assign x_d = work_a[DIM_W-1:0];
    assign y_d = rem_a[DIM_W-1:0];

    // Complement and transpose share one multiplier.
    always_comb
    begin
        if (ctrl_in.mode == nstd_pkg::MODE_COMPLEMENT)
        begin
            mul_a = size_x - DIM_W'(1) - x_d;
            mul_b = size_y;
            add_c = size_y - DIM_W'(1) - y_d;
        end
        else
        begin
            mul_a = y_d;
            mul_b = size_x;
            add_c = x_d;
        end
        linear = CW'(mul_a) * CW'(mul_b) + CW'(add_c);
    end

    // Bit-reverse over xb + yb bits of (x << yb) + y.
    always_comb
    begin
        xb     = bits_for(size_x);
        yb     = bits_for(size_y);
        nbits  = {1'b0, xb} + {1'b0, yb};
        shamt  = (BW+1)'(W) - nbits;
        joined = (W'(x_d[XB-1:0]) << yb) + W'(y_d);
        for (int i = 0; i < W; i++)
        begin
            rev[i] = joined[W-1-i];
        end
        rev_out = rev >> shamt;
    end

    always_comb
    begin
        case (ctrl_in.mode)
            nstd_pkg::MODE_UNIFORM:    dest = DW'(rem_b);
            nstd_pkg::MODE_COMPLEMENT: dest = DW'(linear);
            nstd_pkg::MODE_TRANSPOSE:  dest = DW'(linear);
            nstd_pkg::MODE_REVERSE:    dest = DW'(rev_out);
            default:                   dest = '0;
        endcase
        if (ctrl_in.out_of_range)
        begin
            dest = '0;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        rsp_next   = rsp_reg;
        if (ready_up)
        begin
            valid_next                   = ctrl_in.valid;
            rsp_next.destination_node    = dest[7:0];
            rsp_next.source_out_of_range = ctrl_in.out_of_range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = valid_reg;

endmodule

@@ rtl/core/noc_synthetic_traffic_destination.sv @@
// Top level: config registers, range check and the row of division cells feeding the mapper.
//
// Maps an injecting node of a mesh_columns_x by mesh_rows_y mesh to the destination that
// traffic_mode selects (1 uniform random, 2 bit-complement, 3 transpose, 4 bit-reverse).
// Sizes of 0 act as 1 and sizes above MAX_DIM act as MAX_DIM; a source at or above the node
// count sets source_out_of_range and returns destination 0, as does an unknown mode.
// An item can enter in every cycle unless the row is backed up to a stalled result, and
// the source split (source / rows) and the random reduction (random % node count) run
// side by side through a row of min(RANDOM_BITS,16) restoring-division cells, one quotient
// bit per cell, and the mapping cell with the output register closes the row. Each cell
// moves its item on whenever the cell behind it is empty or moving, so bubbles are
// squeezed out and items are still taken while a finished result waits on rsp_ready.
// Registers: mesh_columns_x at 0x0, mesh_rows_y at 0x4, traffic_mode at 0x8; write only
// while no item is in flight.
module noc_synthetic_traffic_destination #(
    parameter int MAX_DIM     = nstd_pkg::MAX_DIM_DEFAULT,
    parameter int RANDOM_BITS = nstd_pkg::RANDOM_BITS_DEFAULT
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // config port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [nstd_pkg::ADDR_W-1:0] paddr,
    input  logic [nstd_pkg::DATA_W-1:0] pwdata,
    output logic [nstd_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    // request items
    input  logic                        req_valid,
    output logic                        req_ready,
    input  nstd_pkg::req_t              req,
    // result items
    output logic                        rsp_valid,
    input  logic                        rsp_ready,
    output nstd_pkg::rsp_t              rsp
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = 2 * DIM_W;            // node count and remainders
    localparam int N     = (RANDOM_BITS < 16) ? RANDOM_BITS : 16;  // dividend bits, cells
    localparam int CMP_W = (CW > 8) ? CW : 8;

    localparam int SRW = nstd_pkg::SIZE_REG_W;
    localparam int MRW = nstd_pkg::MODE_REG_W;

    // ---------------------------------------------------------------- config registers
    logic [SRW-1:0] columns_reg, columns_next;
    logic [SRW-1:0] rows_reg, rows_next;
    logic [MRW-1:0] mode_reg, mode_next;

    nstd_pkg::reg_index_t reg_index;
    logic                 cfg_write;

    assign pready    = 1'b1;
    assign reg_index = nstd_pkg::reg_index_t'(paddr[3:2]);
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        columns_next = columns_reg;
        rows_next    = rows_reg;
        mode_next    = mode_reg;
        if (cfg_write)
        begin
            case (reg_index)
                nstd_pkg::REG_COLUMNS: columns_next = pwdata[SRW-1:0];
                nstd_pkg::REG_ROWS:    rows_next    = pwdata[SRW-1:0];
                nstd_pkg::REG_MODE:    mode_next    = pwdata[MRW-1:0];
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            columns_reg <= nstd_pkg::COLUMNS_RESET;
            rows_reg    <= nstd_pkg::ROWS_RESET;
            mode_reg    <= nstd_pkg::MODE_RESET;
        end
        else
        begin
            columns_reg <= columns_next;
            rows_reg    <= rows_next;
            mode_reg    <= mode_next;
        end
    end

    always_comb
    begin
        case (reg_index)
            nstd_pkg::REG_COLUMNS: prdata = nstd_pkg::DATA_W'(columns_reg);
            nstd_pkg::REG_ROWS:    prdata = nstd_pkg::DATA_W'(rows_reg);
            nstd_pkg::REG_MODE:    prdata = nstd_pkg::DATA_W'(mode_reg);
            default:               prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- mesh geometry
    // Clamp a size register into 1..MAX_DIM.
    function automatic logic [DIM_W-1:0] eff_size(input logic [SRW-1:0] r);
        if (r == '0)
        begin
            return DIM_W'(1);
        end
        else if (32'(r) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(r);
    endfunction

    logic [DIM_W-1:0] size_x, size_y;
    logic [CW-1:0]    node_count;
    logic             source_oor;

    assign size_x     = eff_size(columns_reg);
    assign size_y     = eff_size(rows_reg);
    assign node_count = CW'(size_x) * CW'(size_y);
    assign source_oor = CMP_W'(req.source_node) >= CMP_W'(node_count);

    // ---------------------------------------------------------------- cell row
    nstd_pkg::ctrl_t ctrl  [0:N];
    logic            ready [0:N];
    logic [CW-1:0]   rem_a [0:N];
    logic [CW-1:0]   rem_b [0:N];
    logic [N-1:0]    work_a [0:N];
    logic [N-1:0]    work_b [0:N];

    assign ctrl[0]   = '{valid: req_valid, mode: mode_reg, out_of_range: source_oor};
    assign rem_a[0]  = '0;
    assign rem_b[0]  = '0;
    assign work_a[0] = N'(req.source_node);
    assign work_b[0] = req.random_value[N-1:0];
    assign req_ready = ready[0];

    for (genvar i = 0; i < N; i++)
    begin : g_cell
        nstd_div_cell #(
            .N  (N),
            .RW (CW)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl_in    (ctrl[i]),
            .ready_up   (ready[i]),
            .rem_a_in   (rem_a[i]),
            .work_a_in  (work_a[i]),
            .rem_b_in   (rem_b[i]),
            .work_b_in  (work_b[i]),
            .divisor_a  (CW'(size_y)),
            .divisor_b  (node_count),
            .ctrl_out   (ctrl[i+1]),
            .ready_down (ready[i+1]),
            .rem_a_out  (rem_a[i+1]),
            .work_a_out (work_a[i+1]),
            .rem_b_out  (rem_b[i+1]),
            .work_b_out (work_b[i+1])
        );
    end

    // ---------------------------------------------------------------- mapping + output
    nstd_map_stage #(
        .MAX_DIM (MAX_DIM),
        .N       (N),
        .RW      (CW)
    ) u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (ctrl[N]),
        .ready_up  (ready[N]),
        .rem_a     (rem_a[N]),
        .work_a    (work_a[N]),
        .rem_b     (rem_b[N]),
        .size_x    (size_x),
        .size_y    (size_y),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready)
    );

    // ---------------------------------------------------------------- assertions
    // An out-of-range source never yields a nonzero destination.
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.source_out_of_range |-> rsp.destination_node == 8'd0)
        else $error("out-of-range source gave a nonzero destination");

    // Uniform, complement and transpose stay inside the mesh for an in-range source.
    a_dest_in_mesh: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.source_out_of_range
        && (mode_reg == nstd_pkg::MODE_UNIFORM || mode_reg == nstd_pkg::MODE_COMPLEMENT
            || mode_reg == nstd_pkg::MODE_TRANSPOSE)
        |-> CMP_W'(rsp.destination_node) < CMP_W'(node_count))
        else $error("destination outside the mesh");

    // Requests are only refused when the row is backed up to a stalled result.
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        !req_ready |-> rsp_valid && !rsp_ready)
        else $error("request refused without an output stall");

endmodule
